/* hdl/qau_pkg.sv */
// qau_pkg: shared widths, opcodes and control types of the quaternion arithmetic unit
// no dependencies; every other file in hdl uses it by scoped names
package qau_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRACTION_BITS = 16;
	localparam int PROD_W = 2 * VALUE_WIDTH;
	// four shifted products plus the constant one never reach the top bits
	localparam int SUM_W = PROD_W + 3;
	localparam int NUM_TERMS = 4;
	localparam int NUM_PRODS = 16;
	localparam int NUM_MAT = 9;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_SCALE = 3'd3;
	localparam logic [2:0] OP_ROT = 3'd4;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// term selection for one sum and saturate unit
	typedef struct packed {
		logic [NUM_TERMS-1:0] used;
		logic [NUM_TERMS-1:0] neg;
		logic                 dbl;
		logic                 add_one;
	} term_ctl_t;

endpackage

/* hdl/qau_op_if.sv */
// qau_op_if: operand channel of the quaternion arithmetic unit, valid/ready with payload
// depends on qau_pkg for the value type
interface qau_op_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	qau_pkg::value_t   a_x;
	qau_pkg::value_t   a_y;
	qau_pkg::value_t   a_z;
	qau_pkg::value_t   a_w;
	qau_pkg::value_t   b_x;
	qau_pkg::value_t   b_y;
	qau_pkg::value_t   b_z;
	qau_pkg::value_t   b_w;
	qau_pkg::value_t   scale_factor;

	modport source (
		output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
		input  ready
	);
	modport sink (
		input  valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
		output ready
	);
endinterface

/* hdl/qau_res_if.sv */
// qau_res_if: result channel of the quaternion arithmetic unit, valid/ready with payload
// depends on qau_pkg for the value type
interface qau_res_if;
	logic              valid;
	logic              ready;
	qau_pkg::value_t   r_x;
	qau_pkg::value_t   r_y;
	qau_pkg::value_t   r_z;
	qau_pkg::value_t   r_w;
	logic              overflow;

	modport source (
		output valid, r_x, r_y, r_z, r_w, overflow,
		input  ready
	);
	modport sink (
		input  valid, r_x, r_y, r_z, r_w, overflow,
		output ready
	);
endinterface

/* hdl/quaternion_arithmetic_unit_core.sv */
// quaternion_arithmetic_unit_core: four-stage pipelined fixed-point quaternion unit
// depends on qau_pkg, qau_op_if, qau_res_if and qau_sum_sat
//
// Usage: unless stalled, one operand word per cycle goes in on the operand
// channel (opcode, quaternion a, operand b, scale factor, all signed Q16.16);
// one result word per operand comes out on the result channel, in order
// (r_x..r_w, overflow). Opcodes: add, subtract, Hamilton product, scale,
// rotate vector (b_x,b_y,b_z) by a with r_w = 0; unused opcodes give an
// all-zero result.
// Throughput: one word per cycle unless stalled; the four stages are a
// multiplier bank, a sum/saturate stage, a second multiplier bank for the
// rotation matrix, and a final sum/saturate stage feeding the output register.
// Stall: each full stage holds while the one after it is full and stalled, so a
// held result.ready backs up through the stages to operand.ready; bubbles
// close up, nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits at once; the unit is ready as
// soon as reset is released, holding no state between words.
module quaternion_arithmetic_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	qau_op_if.sink     operand,
	qau_res_if.source  result
);

	// rotation: doubled products xx yy zz xy xz yz wx wy wz
	localparam int ROT_A [qau_pkg::NUM_MAT] = '{0, 1, 2, 0, 0, 1, 3, 3, 3};
	localparam int ROT_B [qau_pkg::NUM_MAT] = '{0, 1, 2, 1, 2, 2, 0, 1, 2};
	// matrix entries as first term, second term, signs and the added one
	localparam int MAT_A [qau_pkg::NUM_MAT] = '{1, 3, 4, 3, 0, 5, 4, 5, 0};
	localparam int MAT_B [qau_pkg::NUM_MAT] = '{2, 8, 7, 8, 2, 6, 7, 6, 1};
	localparam logic [qau_pkg::NUM_MAT-1:0] MAT_NEG_A = 9'b1_0001_0001;
	localparam logic [qau_pkg::NUM_MAT-1:0] MAT_NEG_B = 9'b1_0111_0011;
	localparam logic [qau_pkg::NUM_MAT-1:0] MAT_ONE = 9'b1_0001_0001;
	// hamilton product term signs per component x y z w
	localparam logic [qau_pkg::NUM_TERMS-1:0] MUL_NEG [4] =
		'{4'b0100, 4'b0001, 4'b0010, 4'b0111};

	// handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// stage registers
	logic [2:0]      op_s1, op_s2, op_s3;
	qau_pkg::prod_t  prod_s1 [qau_pkg::NUM_PRODS];
	qau_pkg::value_t vec_s1 [3];
	qau_pkg::value_t vec_s2 [3];
	qau_pkg::value_t res_s1 [4];
	qau_pkg::value_t res_s2 [4];
	qau_pkg::value_t res_s3 [4];
	logic            ov_s1, ov_s2, ov_s3;
	qau_pkg::value_t mat_s2 [qau_pkg::NUM_MAT];
	qau_pkg::prod_t  mprod_s3 [qau_pkg::NUM_MAT];
	qau_pkg::value_t r_x_s4, r_y_s4, r_z_s4, r_w_s4;
	logic            ov_s4;

	// stage 1 logic
	qau_pkg::value_t a_vec [4];
	qau_pkg::value_t b_vec [4];
	qau_pkg::value_t mul_a [qau_pkg::NUM_PRODS];
	qau_pkg::value_t mul_b [qau_pkg::NUM_PRODS];
	qau_pkg::prod_t  prod_c [qau_pkg::NUM_PRODS];
	qau_pkg::value_t addsub_c [4];
	logic            addsub_ov;
	logic signed [qau_pkg::VALUE_WIDTH:0] wide_c [4];

	// stage 2 logic
	qau_pkg::prod_t     q_term [4][qau_pkg::NUM_TERMS];
	qau_pkg::term_ctl_t q_ctl [4];
	qau_pkg::value_t    q_val [4];
	logic [3:0]         q_ov;
	qau_pkg::prod_t     m_term [qau_pkg::NUM_MAT][qau_pkg::NUM_TERMS];
	qau_pkg::term_ctl_t m_ctl [qau_pkg::NUM_MAT];
	qau_pkg::value_t    m_val [qau_pkg::NUM_MAT];
	logic [qau_pkg::NUM_MAT-1:0] m_ov;
	qau_pkg::value_t    res_c2 [4];
	logic               ov_c2;

	// stage 4 logic
	qau_pkg::prod_t     v_term [3][qau_pkg::NUM_TERMS];
	qau_pkg::term_ctl_t v_ctl;
	qau_pkg::value_t    v_val [3];
	logic [2:0]         v_ov;

	assign rdy_s4 = !v_s4 || result.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign operand.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= operand.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ---------------- stage 1: operand select, multiplier bank, add/sub
	assign a_vec = '{operand.a_x, operand.a_y, operand.a_z, operand.a_w};
	assign b_vec = '{operand.b_x, operand.b_y, operand.b_z, operand.b_w};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 4; i++) begin
				unique case (operand.opcode)
					qau_pkg::OP_SCALE: begin
						mul_a[4*k+i] = a_vec[k];
						mul_b[4*k+i] = operand.scale_factor;
					end
					qau_pkg::OP_ROT: begin
						if (4*k+i < qau_pkg::NUM_MAT) begin
							mul_a[4*k+i] = a_vec[ROT_A[4*k+i]];
							mul_b[4*k+i] = a_vec[ROT_B[4*k+i]];
						end else begin
							mul_a[4*k+i] = '0;
							mul_b[4*k+i] = '0;
						end
					end
					default: begin
						// hamilton term: a component i times b component i xor ~k
						mul_a[4*k+i] = a_vec[i];
						mul_b[4*k+i] = b_vec[i ^ k ^ 3];
					end
				endcase
			end
		end
		for (int p = 0; p < qau_pkg::NUM_PRODS; p++) begin
			prod_c[p] = qau_pkg::PROD_W'(mul_a[p]) * qau_pkg::PROD_W'(mul_b[p]);
		end
	end

	always_comb begin
		addsub_ov = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (operand.opcode == qau_pkg::OP_SUB) begin
				wide_c[i] = {a_vec[i][qau_pkg::VALUE_WIDTH-1], a_vec[i]}
					- {b_vec[i][qau_pkg::VALUE_WIDTH-1], b_vec[i]};
			end else begin
				wide_c[i] = {a_vec[i][qau_pkg::VALUE_WIDTH-1], a_vec[i]}
					+ {b_vec[i][qau_pkg::VALUE_WIDTH-1], b_vec[i]};
			end
			// top two bits differ only when the sum left the value range
			if (wide_c[i][qau_pkg::VALUE_WIDTH] != wide_c[i][qau_pkg::VALUE_WIDTH-1]) begin
				addsub_c[i] = wide_c[i][qau_pkg::VALUE_WIDTH]
					? {1'b1, {(qau_pkg::VALUE_WIDTH - 1){1'b0}}}
					: {1'b0, {(qau_pkg::VALUE_WIDTH - 1){1'b1}}};
				addsub_ov = 1'b1;
			end else begin
				addsub_c[i] = wide_c[i][qau_pkg::VALUE_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1 <= operand.opcode;
			prod_s1 <= prod_c;
			vec_s1 <= '{operand.b_x, operand.b_y, operand.b_z};
			if (operand.opcode == qau_pkg::OP_ADD || operand.opcode == qau_pkg::OP_SUB) begin
				res_s1 <= addsub_c;
				ov_s1 <= addsub_ov;
			end else begin
				res_s1 <= '{default: '0};
				ov_s1 <= 1'b0;
			end
		end
	end

	// ---------------- stage 2: product sums and rotation matrix entries
	generate
		for (genvar k = 0; k < 4; k++) begin : g_quat
			for (genvar i = 0; i < qau_pkg::NUM_TERMS; i++) begin : g_term
				assign q_term[k][i] = prod_s1[4*k+i];
			end
			always_comb begin
				q_ctl[k].dbl = 1'b0;
				q_ctl[k].add_one = 1'b0;
				if (op_s1 == qau_pkg::OP_SCALE) begin
					q_ctl[k].used = 4'b0001;
					q_ctl[k].neg = 4'b0000;
				end else begin
					q_ctl[k].used = 4'b1111;
					q_ctl[k].neg = MUL_NEG[k];
				end
			end
			qau_sum_sat u_quat (
				.term  (q_term[k]),
				.ctl   (q_ctl[k]),
				.value (q_val[k]),
				.ov    (q_ov[k])
			);
		end

		for (genvar j = 0; j < qau_pkg::NUM_MAT; j++) begin : g_mat
			assign m_term[j][0] = prod_s1[MAT_A[j]];
			assign m_term[j][1] = prod_s1[MAT_B[j]];
			assign m_term[j][2] = '0;
			assign m_term[j][3] = '0;
			assign m_ctl[j] = '{
				used:    4'b0011,
				neg:     {2'b00, MAT_NEG_B[j], MAT_NEG_A[j]},
				dbl:     1'b1,
				add_one: MAT_ONE[j]
			};
			qau_sum_sat u_mat (
				.term  (m_term[j]),
				.ctl   (m_ctl[j]),
				.value (m_val[j]),
				.ov    (m_ov[j])
			);
		end
	endgenerate

	always_comb begin
		unique case (op_s1)
			qau_pkg::OP_MUL, qau_pkg::OP_SCALE: begin
				res_c2 = q_val;
				ov_c2 = |q_ov;
			end
			qau_pkg::OP_ROT: begin
				res_c2 = '{default: '0};
				ov_c2 = |m_ov;
			end
			default: begin
				res_c2 = res_s1;
				ov_c2 = ov_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			op_s2 <= op_s1;
			res_s2 <= res_c2;
			ov_s2 <= ov_c2;
			mat_s2 <= m_val;
			vec_s2 <= vec_s1;
		end
	end

	// ---------------- stage 3: matrix times vector products
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			op_s3 <= op_s2;
			res_s3 <= res_s2;
			ov_s3 <= ov_s2;
			for (int j = 0; j < qau_pkg::NUM_MAT; j++) begin
				mprod_s3[j] <= qau_pkg::PROD_W'(mat_s2[j]) * qau_pkg::PROD_W'(vec_s2[j % 3]);
			end
		end
	end

	// ---------------- stage 4: row sums and output register
	assign v_ctl = '{used: 4'b0111, neg: 4'b0000, dbl: 1'b0, add_one: 1'b0};

	generate
		for (genvar r = 0; r < 3; r++) begin : g_row
			for (genvar c = 0; c < 3; c++) begin : g_col
				assign v_term[r][c] = mprod_s3[3*r+c];
			end
			assign v_term[r][3] = '0;
			qau_sum_sat u_row (
				.term  (v_term[r]),
				.ctl   (v_ctl),
				.value (v_val[r]),
				.ov    (v_ov[r])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			if (op_s3 == qau_pkg::OP_ROT) begin
				r_x_s4 <= v_val[0];
				r_y_s4 <= v_val[1];
				r_z_s4 <= v_val[2];
				r_w_s4 <= '0;
				ov_s4 <= ov_s3 | (|v_ov);
			end else begin
				r_x_s4 <= res_s3[0];
				r_y_s4 <= res_s3[1];
				r_z_s4 <= res_s3[2];
				r_w_s4 <= res_s3[3];
				ov_s4 <= ov_s3;
			end
		end
	end

	assign result.valid = v_s4;
	assign result.r_x = r_x_s4;
	assign result.r_y = r_y_s4;
	assign result.r_z = r_z_s4;
	assign result.r_w = r_w_s4;
	assign result.overflow = ov_s4;

endmodule

/* hdl/qau_sum_sat.sv */
// qau_sum_sat: floors up to four products, doubled on request, to fixed point,
// adds them with signs, may add 1.0, saturates to the value range; uses qau_pkg
module qau_sum_sat (
	input  qau_pkg::prod_t    term [qau_pkg::NUM_TERMS],
	input  qau_pkg::term_ctl_t ctl,
	output qau_pkg::value_t   value,
	output logic              ov
);

	localparam logic signed [qau_pkg::SUM_W-1:0] ONE =
		qau_pkg::SUM_W'(1) <<< qau_pkg::FRACTION_BITS;
	localparam logic signed [qau_pkg::SUM_W-1:0] SMAX =
		(qau_pkg::SUM_W'(1) <<< (qau_pkg::VALUE_WIDTH - 1)) - qau_pkg::SUM_W'(1);
	localparam logic signed [qau_pkg::SUM_W-1:0] SMIN = -SMAX - qau_pkg::SUM_W'(1);

	logic signed [qau_pkg::SUM_W-1:0] acc;
	logic signed [qau_pkg::SUM_W-1:0] sh [qau_pkg::NUM_TERMS];

	always_comb begin
		acc = ctl.add_one ? ONE : '0;
		for (int i = 0; i < qau_pkg::NUM_TERMS; i++) begin
			// arithmetic shift floors toward minus infinity
			if (ctl.dbl) begin
				sh[i] = qau_pkg::SUM_W'(term[i] >>> (qau_pkg::FRACTION_BITS - 1));
			end else begin
				sh[i] = qau_pkg::SUM_W'(term[i] >>> qau_pkg::FRACTION_BITS);
			end
			if (ctl.used[i]) begin
				acc = ctl.neg[i] ? acc - sh[i] : acc + sh[i];
			end
		end
		ov = 1'b0;
		if (acc > SMAX) begin
			value = {1'b0, {(qau_pkg::VALUE_WIDTH - 1){1'b1}}};
			ov = 1'b1;
		end else if (acc < SMIN) begin
			value = {1'b1, {(qau_pkg::VALUE_WIDTH - 1){1'b0}}};
			ov = 1'b1;
		end else begin
			value = acc[qau_pkg::VALUE_WIDTH-1:0];
		end
	end

endmodule

/* tb/tb_quaternion_arithmetic_unit_core.sv */
`timescale 1ns / 100ps
// tb_quaternion_arithmetic_unit_core: self-checking bench for the quaternion unit, a directed
// table then random words, each result checked in order against its table entry or a fixed-point predictor
// depends on qau_pkg, qau_op_if, qau_res_if and quaternion_arithmetic_unit_core
module tb_quaternion_arithmetic_unit_core;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam qau_pkg::value_t Q_ONE = 32'sh0001_0000;
	localparam qau_pkg::value_t Q_NEG_ONE = -32'sh0001_0000;
	localparam qau_pkg::value_t Q_MAX = 32'sh7FFF_FFFF;
	localparam qau_pkg::value_t Q_MIN = 32'sh8000_0000;
	localparam qau_pkg::value_t Q_LSB = 32'sh0000_0001;
	localparam qau_pkg::value_t Q_NEG_LSB = -32'sh0000_0001;

	localparam longint VAL_MAX = (longint'(1) << (qau_pkg::VALUE_WIDTH - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	localparam int RAND_ITEMS = 1530;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [2:0]      opcode;
		qau_pkg::value_t a_x;
		qau_pkg::value_t a_y;
		qau_pkg::value_t a_z;
		qau_pkg::value_t a_w;
		qau_pkg::value_t b_x;
		qau_pkg::value_t b_y;
		qau_pkg::value_t b_z;
		qau_pkg::value_t b_w;
		qau_pkg::value_t scale;
	} quat_op_t;

	typedef struct packed {
		qau_pkg::value_t r_x;
		qau_pkg::value_t r_y;
		qau_pkg::value_t r_z;
		qau_pkg::value_t r_w;
		logic            overflow;
	} quat_res_t;

	logic clk = 1'b0;
	logic arst_n;

	qau_op_if  op_if ();
	qau_res_if res_if ();

	quaternion_arithmetic_unit_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (op_if),
		.result  (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quat_res_t   pending_q[$];
	quat_op_t    dir_op[$];
	quat_res_t   dir_want[$];
	bit          dir_fixed[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_req;
	int          err_cnt;
	int          res_idx;
	int          quiet_cycles;

	// ---------------- predictor ----------------

	function automatic longint clip(input longint v, inout bit ovf);
		if (v > VAL_MAX) begin
			ovf = 1'b1;
			return VAL_MAX;
		end
		if (v < VAL_MIN) begin
			ovf = 1'b1;
			return VAL_MIN;
		end
		return v;
	endfunction

	// truncating fixed-point product, floor toward minus infinity
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b) >>> qau_pkg::FRACTION_BITS;
	endfunction

	// doubled product used by the rotation matrix
	function automatic longint fx_mul2(input longint a, input longint b);
		return (a * b) >>> (qau_pkg::FRACTION_BITS - 1);
	endfunction

	function automatic quat_res_t predict_quat(input quat_op_t w);
		longint ax, ay, az, aw, bx, by, bz, bw, s, one;
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
		bit ovf;
		quat_res_t r;
		ax = w.a_x; ay = w.a_y; az = w.a_z; aw = w.a_w;
		bx = w.b_x; by = w.b_y; bz = w.b_z; bw = w.b_w;
		s = w.scale;
		one = longint'(1) << qau_pkg::FRACTION_BITS;
		ovf = 1'b0;
		r = '0;
		unique case (w.opcode)
		qau_pkg::OP_ADD: begin
			r.r_x = qau_pkg::value_t'(clip(ax + bx, ovf));
			r.r_y = qau_pkg::value_t'(clip(ay + by, ovf));
			r.r_z = qau_pkg::value_t'(clip(az + bz, ovf));
			r.r_w = qau_pkg::value_t'(clip(aw + bw, ovf));
		end
		qau_pkg::OP_SUB: begin
			r.r_x = qau_pkg::value_t'(clip(ax - bx, ovf));
			r.r_y = qau_pkg::value_t'(clip(ay - by, ovf));
			r.r_z = qau_pkg::value_t'(clip(az - bz, ovf));
			r.r_w = qau_pkg::value_t'(clip(aw - bw, ovf));
		end
		qau_pkg::OP_MUL: begin
			r.r_x = qau_pkg::value_t'(clip(fx_mul(ax, bw) + fx_mul(ay, bz)
				- fx_mul(az, by) + fx_mul(aw, bx), ovf));
			r.r_y = qau_pkg::value_t'(clip(-fx_mul(ax, bz) + fx_mul(ay, bw)
				+ fx_mul(az, bx) + fx_mul(aw, by), ovf));
			r.r_z = qau_pkg::value_t'(clip(fx_mul(ax, by) - fx_mul(ay, bx)
				+ fx_mul(az, bw) + fx_mul(aw, bz), ovf));
			r.r_w = qau_pkg::value_t'(clip(-fx_mul(ax, bx) - fx_mul(ay, by)
				- fx_mul(az, bz) + fx_mul(aw, bw), ovf));
		end
		qau_pkg::OP_SCALE: begin
			r.r_x = qau_pkg::value_t'(clip(fx_mul(ax, s), ovf));
			r.r_y = qau_pkg::value_t'(clip(fx_mul(ay, s), ovf));
			r.r_z = qau_pkg::value_t'(clip(fx_mul(az, s), ovf));
			r.r_w = qau_pkg::value_t'(clip(fx_mul(aw, s), ovf));
		end
		qau_pkg::OP_ROT: begin
			xx = fx_mul2(ax, ax); yy = fx_mul2(ay, ay); zz = fx_mul2(az, az);
			xy = fx_mul2(ax, ay); xz = fx_mul2(ax, az); yz = fx_mul2(ay, az);
			wx = fx_mul2(aw, ax); wy = fx_mul2(aw, ay); wz = fx_mul2(aw, az);
			// matrix entries saturate on their own before use
			m00 = clip(one - (yy + zz), ovf);
			m01 = clip(xy - wz, ovf);
			m02 = clip(xz + wy, ovf);
			m10 = clip(xy + wz, ovf);
			m11 = clip(one - (xx + zz), ovf);
			m12 = clip(yz - wx, ovf);
			m20 = clip(xz - wy, ovf);
			m21 = clip(yz + wx, ovf);
			m22 = clip(one - (xx + yy), ovf);
			r.r_x = qau_pkg::value_t'(clip(fx_mul(m00, bx) + fx_mul(m01, by)
				+ fx_mul(m02, bz), ovf));
			r.r_y = qau_pkg::value_t'(clip(fx_mul(m10, bx) + fx_mul(m11, by)
				+ fx_mul(m12, bz), ovf));
			r.r_z = qau_pkg::value_t'(clip(fx_mul(m20, bx) + fx_mul(m21, by)
				+ fx_mul(m22, bz), ovf));
		end
		default: begin
			r = '0;
		end
		endcase
		r.overflow = ovf;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic quat_op_t mk_op(input logic [2:0] op, input qau_pkg::value_t ax,
		input qau_pkg::value_t ay, input qau_pkg::value_t az, input qau_pkg::value_t aw,
		input qau_pkg::value_t bx, input qau_pkg::value_t by, input qau_pkg::value_t bz,
		input qau_pkg::value_t bw, input qau_pkg::value_t s);
		quat_op_t w;
		w.opcode = op;
		w.a_x = ax; w.a_y = ay; w.a_z = az; w.a_w = aw;
		w.b_x = bx; w.b_y = by; w.b_z = bz; w.b_w = bw;
		w.scale = s;
		return w;
	endfunction

	function automatic quat_res_t mk_res(input qau_pkg::value_t x, input qau_pkg::value_t y,
		input qau_pkg::value_t z, input qau_pkg::value_t w, input logic ovf);
		quat_res_t r;
		r.r_x = x; r.r_y = y; r.r_z = z; r.r_w = w;
		r.overflow = ovf;
		return r;
	endfunction

	task automatic add_row(input quat_op_t w, input bit fixed, input quat_res_t want);
		dir_op.push_back(w);
		dir_fixed.push_back(fixed);
		dir_want.push_back(want);
	endtask

	function automatic qau_pkg::value_t rand_value();
		int unsigned pick;
		pick = $urandom_range(9);
		case (pick)
		0, 1, 2, 3: begin
			return qau_pkg::value_t'($urandom);
		end
		4, 5, 6: begin
			return qau_pkg::value_t'(int'($urandom_range(32'h0008_0000)) - 32'h0004_0000);
		end
		7: begin
			return qau_pkg::value_t'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
		end
		default: begin
			case ($urandom_range(6))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return Q_ONE;
			4: return Q_NEG_ONE;
			5: return Q_NEG_LSB;
			default: return Q_LSB;
			endcase
		end
		endcase
	endfunction

	// near-unit quaternion components
	function automatic qau_pkg::value_t rand_unit();
		return qau_pkg::value_t'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
	endfunction

	// vector components within +-256.0
	function automatic qau_pkg::value_t rand_vec();
		return qau_pkg::value_t'(int'($urandom_range(32'h0200_0000)) - 32'h0100_0000);
	endfunction

	function automatic quat_op_t rand_item();
		quat_op_t w;
		logic [2:0] op;
		if ($urandom_range(99) < 4)
			op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else
			op = 3'($urandom_range(qau_pkg::OP_ADD, qau_pkg::OP_ROT));
		if (op == qau_pkg::OP_ROT && $urandom_range(99) < 70)
			w = mk_op(op, rand_unit(), rand_unit(), rand_unit(), rand_unit(),
				rand_vec(), rand_vec(), rand_vec(), qau_pkg::value_t'($urandom),
				qau_pkg::value_t'($urandom));
		else
			w = mk_op(op, rand_value(), rand_value(), rand_value(), rand_value(),
				rand_value(), rand_value(), rand_value(), rand_value(), rand_value());
		return w;
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic push_word(input quat_op_t w, input bit fixed, input quat_res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			op_if.valid <= 1'b0;
			@(negedge clk);
		end
		op_if.valid <= 1'b1;
		op_if.opcode <= w.opcode;
		op_if.a_x <= w.a_x;
		op_if.a_y <= w.a_y;
		op_if.a_z <= w.a_z;
		op_if.a_w <= w.a_w;
		op_if.b_x <= w.b_x;
		op_if.b_y <= w.b_y;
		op_if.b_z <= w.b_z;
		op_if.b_w <= w.b_w;
		op_if.scale_factor <= w.scale;
		@(posedge clk);
		while (!op_if.ready)
			@(posedge clk);
		pending_q.push_back(fixed ? want : predict_quat(w));
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint want);
		if (err_cnt < MAX_PRINTS)
			$display("[%0t] result %0d %s: got %h, expected %h", $time, res_idx, field,
				got, want);
		err_cnt++;
	endtask

	// ---------------- main sequence ----------------

	initial begin : stimulus
		arst_n = 1'b0;
		op_if.valid = 1'b0;
		op_if.opcode = qau_pkg::OP_ADD;
		op_if.a_x = '0; op_if.a_y = '0; op_if.a_z = '0; op_if.a_w = '0;
		op_if.b_x = '0; op_if.b_y = '0; op_if.b_z = '0; op_if.b_w = '0;
		op_if.scale_factor = '0;
		send_idle_pct = 26;
		recv_idle_pct = 80;
		hold_req = 1'b0;
		err_cnt = 0;

		// sums that hit both rails
		add_row(mk_op(qau_pkg::OP_ADD, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
			mk_res('0, '0, '0, '0, 1'b0));
		add_row(mk_op(qau_pkg::OP_ADD, Q_MAX, Q_MIN, Q_LSB, Q_NEG_LSB, Q_LSB, Q_NEG_LSB,
			32'sh2, -32'sh2, '0), 1'b1, mk_res(Q_MAX, Q_MIN, 32'sh3, -32'sh3, 1'b1));
		add_row(mk_op(qau_pkg::OP_SUB, Q_MIN, Q_MAX, 32'sh5, '0, Q_LSB, Q_NEG_LSB, 32'sh7,
			Q_MIN, '0), 1'b1, mk_res(Q_MIN, Q_MAX, -32'sh2, Q_MAX, 1'b1));
		add_row(mk_op(qau_pkg::OP_SUB, 32'sh0003_8000, -32'sh0002_0000, 32'sh1234_5678,
			-32'sh5, 32'sh0001_4000, 32'sh0007_0000, -32'sh0FED_CBA9, 32'sh9, '0), 1'b0,
			'0);
		// hamilton product: identity, i*j = k, floor of a negative product
		add_row(mk_op(qau_pkg::OP_MUL, '0, '0, '0, Q_ONE, Q_MAX, Q_MIN, 32'sh0003_8000,
			-32'sh7, '0), 1'b1, mk_res(Q_MAX, Q_MIN, 32'sh0003_8000, -32'sh7, 1'b0));
		add_row(mk_op(qau_pkg::OP_MUL, Q_ONE, '0, '0, '0, '0, Q_ONE, '0, '0, '0), 1'b1,
			mk_res('0, '0, Q_ONE, '0, 1'b0));
		add_row(mk_op(qau_pkg::OP_MUL, Q_NEG_LSB, '0, '0, '0, '0, '0, '0, Q_LSB, '0), 1'b1,
			mk_res(Q_NEG_LSB, '0, '0, '0, 1'b0));
		add_row(mk_op(qau_pkg::OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN), 1'b0, '0);
		add_row(mk_op(qau_pkg::OP_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX, Q_MAX), 1'b0, '0);
		add_row(mk_op(qau_pkg::OP_MUL, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN,
			Q_MAX, '0), 1'b0, '0);
		add_row(mk_op(qau_pkg::OP_MUL, 32'sh0000_B505, -32'sh0002_4000, 32'sh0001_0001,
			32'sh0000_8000, -32'sh0000_3333, 32'sh0005_0000, -32'sh0000_0101,
			32'sh0003_C000, '0), 1'b0, '0);
		// scale: unit factor, sign flip of the most negative value, rail on rail
		add_row(mk_op(qau_pkg::OP_SCALE, 32'sh0001_8000, -32'sh0002_4000, Q_MAX, Q_MIN,
			'0, '0, '0, '0, Q_ONE), 1'b1,
			mk_res(32'sh0001_8000, -32'sh0002_4000, Q_MAX, Q_MIN, 1'b0));
		add_row(mk_op(qau_pkg::OP_SCALE, Q_MIN, '0, '0, '0, '0, '0, '0, '0, Q_NEG_ONE),
			1'b1, mk_res(Q_MAX, '0, '0, '0, 1'b1));
		add_row(mk_op(qau_pkg::OP_SCALE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0,
			Q_MIN), 1'b1, mk_res(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
		add_row(mk_op(qau_pkg::OP_SCALE, 32'sh0001_8000, -32'sh0003_4000, 32'sh7FFF_0000,
			-32'sh3, '0, '0, '0, '0, -32'sh0000_8000), 1'b0, '0);
		// rotation: identity leaves the vector alone and ignores b_w
		add_row(mk_op(qau_pkg::OP_ROT, '0, '0, '0, Q_ONE, Q_MAX, Q_MIN, 32'sh0005_0000,
			32'sh0009_0000, '0), 1'b1, mk_res(Q_MAX, Q_MIN, 32'sh0005_0000, '0, 1'b0));
		add_row(mk_op(qau_pkg::OP_ROT, '0, '0, 32'sh0000_B505, 32'sh0000_B505,
			32'sh0003_0000, '0, '0, '0, '0), 1'b0, '0);
		add_row(mk_op(qau_pkg::OP_ROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN), 1'b0, '0);
		add_row(mk_op(qau_pkg::OP_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX, Q_MAX), 1'b0, '0);
		add_row(mk_op(qau_pkg::OP_ROT, 32'sh0000_4000, -32'sh0000_6000, 32'sh0000_2000,
			32'sh0000_C000, 32'sh0010_0000, -32'sh0002_8000, 32'sh0000_0123, '0, '0),
			1'b0, '0);
		// spare opcodes give an all-zero word
		add_row(mk_op(OP_SPARE_LO, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN, Q_MAX, Q_ONE, Q_MIN,
			Q_MAX), 1'b1, mk_res('0, '0, '0, '0, 1'b0));
		add_row(mk_op(OP_SPARE_MID, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN), 1'b1, mk_res('0, '0, '0, '0, 1'b0));
		add_row(mk_op(OP_SPARE_HI, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX), 1'b1, mk_res('0, '0, '0, '0, 1'b0));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_op[k])
			push_word(dir_op[k], dir_fixed[k], dir_want[k]);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 3) begin
				send_idle_pct = 80;
				recv_idle_pct = 26;
			end
			if (i == 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = 1'b1;
			end
			push_word(rand_item(), 1'b0, '0);
		end
		op_if.valid <= 1'b0;

		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("** quaternion_arithmetic_unit_core: PASSED **");
		else
			$display("** quaternion_arithmetic_unit_core: FAILED **");
		$finish;
	end

	// result side ready, with one long hold-off to back up the pipeline
	initial begin : result_drain
		int unsigned hold_left;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		quat_res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected word", res_if.r_x, 0);
			end else begin
				want = pending_q.pop_front();
				if (res_if.r_x !== want.r_x)
					report_mismatch("r_x", res_if.r_x, want.r_x);
				if (res_if.r_y !== want.r_y)
					report_mismatch("r_y", res_if.r_y, want.r_y);
				if (res_if.r_z !== want.r_z)
					report_mismatch("r_z", res_if.r_z, want.r_z);
				if (res_if.r_w !== want.r_w)
					report_mismatch("r_w", res_if.r_w, want.r_w);
				if (res_if.overflow !== want.overflow)
					report_mismatch("overflow", res_if.overflow, want.overflow);
			end
			res_idx++;
		end
	end

	// stall watchdog: cycles with no word moving on either channel
	initial quiet_cycles = 0;
	always @(posedge clk) begin : watchdog
		if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** quaternion_arithmetic_unit_core: FAILED **");
				$finish;
			end
		end
	end

	initial res_idx = 0;

endmodule

/* sim.f */
hdl/qau_pkg.sv
hdl/qau_op_if.sv
hdl/qau_res_if.sv
hdl/qau_sum_sat.sv
hdl/quaternion_arithmetic_unit_core.sv
tb/tb_quaternion_arithmetic_unit_core.sv
